// File: src/bfa_pkg.sv
// Package with the shared constants and codes of the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int FRAME_COUNT = 4096;
    localparam int FRAME_BYTES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int FNUM_W      = $clog2(FRAME_COUNT) + 1;

    // Bits of the last word that lie beyond the last frame read as used.
    localparam logic [WORD_BITS-1:0] PAD_MASK = (FRAME_COUNT % WORD_BITS == 0) ? '0 :
        ~((32'h1 << (FRAME_COUNT % WORD_BITS)) - 32'h1);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

endpackage

// File: src/bfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/bfa_find.sv
// Lowest-clear-bit finder for one bitmap word, a five-step binary search.
`timescale 1ns / 1ps

module bfa_find
    import bfa_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    output logic [4:0]           bit_index
);

    always_comb begin
        logic [WORD_BITS-1:0] z;
        logic [4:0]           idx;
        z   = ~word;
        idx = '0;
        for (int step = 4; step >= 0; step--) begin
            if ((z & ((32'h1 << (1 << step)) - 32'h1)) == '0) begin
                idx = idx | 5'(1 << step);
                z   = z >> (1 << step);
            end
        end
        bit_index = idx;
    end

endmodule

// File: src/bitmap_frame_allocator_core.sv
// Top level of the bitmap first-fit page frame allocator.
`timescale 1ns / 1ps

// The block keeps one used bit per 4 KiB frame in a RAM of 32-bit words and
// serves one request word at a time on the s_ channel: allocate, free or init.
// Every request yields exactly one result word on the m_ channel carrying the
// frame byte address (masked to 24 bits) and a status code.
// The cfg_ channel writes kernel_end_address; it is always ready and is meant
// to be written while the block is idle.
// Work per request, set by the one RAM read port and the sequencer that drives it:
//   allocate : words are read one per cycle until a clear bit is found or the
//              last word has been checked; a found word is written back with
//              the bit set, then the result is delivered.
//   free     : read, modify and write of one word, then result.
//   init     : every word written, one word per cycle, then result.
//   unused op: result only.
// s_tready is high only while the sequencer is idle. A result sits in an
// output register, so the next request may be accepted while the receiver
// stalls; that request finishes its work and then waits for the register.
// After reset a clearing pass writes every word of the bitmap before the first
// request is accepted. Reset does not perform an init and sets
// kernel_end_address to zero.
module bitmap_frame_allocator_core
    import bfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [1:0] op, [33:2] free_address, upper bits zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // m_tdata: [23:0] frame_address, [25:24] status, upper bits zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // Configuration: kernel_end_address.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SWEEP  = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_AFOUND = 3'd3;
    localparam logic [2:0] S_FREERD = 3'd4;
    localparam logic [2:0] S_FREEWR = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [31:0]          kernel_end_reg;
    logic [1:0]           op_reg, op_next;
    logic [19:0]          fnum_reg, fnum_next;
    logic [FNUM_W-1:0]    need_reg, need_next;
    logic [WIDX_W-1:0]    sweep_idx_reg, sweep_idx_next;
    logic [WIDX_W:0]      scan_idx_reg, scan_idx_next;
    logic [WIDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [WIDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [WORD_BITS-1:0] hit_word_reg, hit_word_next;
    logic [23:0]          res_addr_reg, res_addr_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;

    logic                 ram_we;
    logic [WIDX_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WIDX_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [4:0]           hit_bit;

    logic                 s_accept;
    logic [1:0]           in_op;
    logic [31:0]          in_free_address;
    logic [20:0]          need_raw;
    logic [FNUM_W-1:0]    need_words;
    logic [WORD_BITS-1:0] sweep_word;
    logic [63:0]          hit_byte_addr;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_find u_find (
        .word      (hit_word_reg),
        .bit_index (hit_bit)
    );

    assign s_tready        = (state_reg == S_IDLE);
    assign s_accept        = s_tvalid && s_tready;
    assign in_op           = s_tdata[1:0];
    assign in_free_address = s_tdata[33:2];
    assign cfg_ready       = 1'b1;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

    // Frames to reserve: ceil(kernel_end / 4096), computed without wrap-around.
    assign need_raw = 21'((33'(kernel_end_reg) + 33'(FRAME_BYTES - 1)) >> 12);

    // The word written by a sweep: fully reserved words, one partly reserved
    // word, and the padding bits of the last word, which always read as used.
    assign need_words = need_reg >> 5;
    always_comb begin
        sweep_word = '0;
        if (FNUM_W'(sweep_idx_reg) < need_words) begin
            sweep_word = '1;
        end else if (FNUM_W'(sweep_idx_reg) == need_words) begin
            sweep_word = ~({WORD_BITS{1'b1}} << need_reg[4:0]);
        end
        if (sweep_idx_reg == WIDX_W'(WORD_COUNT - 1)) begin
            sweep_word = sweep_word | PAD_MASK;
        end
    end

    assign hit_byte_addr = 64'({hit_idx_reg, hit_bit, 12'h000});

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        fnum_next       = fnum_reg;
        need_next       = need_reg;
        sweep_idx_next  = sweep_idx_reg;
        scan_idx_next   = scan_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = 1'b0;
        hit_idx_next    = hit_idx_reg;
        hit_word_next   = hit_word_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = sweep_idx_reg;
        ram_wdata       = sweep_word;
        ram_raddr       = scan_idx_reg[WIDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next         = in_op;
                    fnum_next       = in_free_address[31:12];
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    scan_idx_next   = '0;
                    sweep_idx_next  = '0;
                    case (in_op)
                        OP_ALLOC: state_next = S_ALLOC;
                        OP_FREE: begin
                            if ({1'b0, in_free_address[31:12]} >= 21'(FRAME_COUNT)) begin
                                res_status_next = ST_BADADDR;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_FREERD;
                            end
                        end
                        OP_INIT: begin
                            need_next  = (need_raw > 21'(FRAME_COUNT)) ?
                                         FNUM_W'(FRAME_COUNT) : need_raw[FNUM_W-1:0];
                            state_next = S_SWEEP;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SWEEP: begin
                ram_we         = 1'b1;
                sweep_idx_next = sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == WIDX_W'(WORD_COUNT - 1)) begin
                    // The pass after reset gives no result; an init does.
                    state_next = (op_reg == OP_INIT) ? S_DONE : S_IDLE;
                end
            end
            S_ALLOC: begin
                // Reads are issued one word per cycle; the word read in the
                // previous cycle is checked for a clear bit.
                if (chk_valid_reg && ram_rdata != '1) begin
                    hit_idx_next  = chk_idx_reg;
                    hit_word_next = ram_rdata;
                    state_next    = S_AFOUND;
                end else if (chk_valid_reg && chk_idx_reg == WIDX_W'(WORD_COUNT - 1)) begin
                    res_status_next = ST_NOMEM;
                    state_next      = S_DONE;
                end else if (scan_idx_reg < (WIDX_W + 1)'(WORD_COUNT)) begin
                    chk_idx_next   = scan_idx_reg[WIDX_W-1:0];
                    chk_valid_next = 1'b1;
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
            end
            S_AFOUND: begin
                ram_we        = 1'b1;
                ram_waddr     = hit_idx_reg;
                ram_wdata     = hit_word_reg | (32'h1 << hit_bit);
                res_addr_next = hit_byte_addr[23:0];
                state_next    = S_DONE;
            end
            S_FREERD: begin
                ram_raddr  = fnum_reg[WIDX_W+4:5];
                state_next = S_FREEWR;
            end
            S_FREEWR: begin
                ram_we     = 1'b1;
                ram_waddr  = fnum_reg[WIDX_W+4:5];
                ram_wdata  = ram_rdata & ~(32'h1 << fnum_reg[4:0]);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, res_status_reg, res_addr_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP;
            kernel_end_reg <= '0;
            op_reg         <= OP_ALLOC;
            need_reg       <= '0;
            sweep_idx_reg  <= '0;
            scan_idx_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            need_reg      <= need_next;
            sweep_idx_reg <= sweep_idx_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                kernel_end_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fnum_reg       <= fnum_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_word_reg   <= hit_word_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // The bitmap is never written while the sequencer is idle or delivering.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !ram_we)
        else $error("bitmap written outside a request");

    // An out-of-memory result always carries frame address zero.
    a_nomem_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[25:24] == ST_NOMEM) |-> (m_tdata[23:0] == 24'h0))
        else $error("out-of-memory result with nonzero address");

    // A bad-address status is only produced for a free request.
    a_badaddr_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_status_reg == ST_BADADDR) |-> (op_reg == OP_FREE))
        else $error("bad-address status outside a free");

    // The scan never runs past the last bitmap word.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC) |-> (scan_idx_reg <= (WIDX_W + 1)'(WORD_COUNT)))
        else $error("allocation scan beyond bitmap");

    // A found word really has a clear bit.
    a_hit_has_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_AFOUND) |-> (hit_word_reg != '1))
        else $error("allocation hit on a full word");

endmodule
